>>> sv/plit_pkg.sv
// Package for the piecewise-linear table interpolation core.
// Holds the word types, codes, controller states and the command and status bundles.
// No dependencies.
package plit_pkg;

    localparam int PLIT_TABLE_DEPTH    = 256;
    localparam int PLIT_FRACTION_BITS  = 16;
    localparam int PLIT_VALUE_W        = 24;
    localparam int PLIT_INDEX_W        = 8;
    localparam int PLIT_COUNT_W        = 9;

    localparam logic       REQ_WRITE    = 1'b0;
    localparam logic       REQ_QUERY    = 1'b1;

    localparam logic [1:0] RANGE_INSIDE = 2'd0;
    localparam logic [1:0] RANGE_BELOW  = 2'd1;
    localparam logic [1:0] RANGE_ABOVE  = 2'd2;

    typedef struct packed {
        logic                      req_type;
        logic [PLIT_INDEX_W-1:0]   entry_index;
        logic [PLIT_VALUE_W-1:0]   radius_value;
        logic [PLIT_VALUE_W-1:0]   density_value;
    } plit_req_t;

    typedef struct packed {
        logic [PLIT_VALUE_W-1:0]   density_out;
        logic [1:0]                range_flag;
    } plit_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_CHK_LAST,
        S_SCAN,
        S_LOWER,
        S_DIV,
        S_MUL_LO,
        S_MUL_HI
    } plit_state_t;

    typedef enum logic [1:0] {
        ADDR_LAST,
        ADDR_ZERO,
        ADDR_NEXT,
        ADDR_PREV
    } plit_addr_sel_t;

    typedef enum logic [1:0] {
        RES_ABOVE,
        RES_BELOW,
        RES_INTERP
    } plit_res_sel_t;

    typedef struct packed {
        logic           latch;
        logic           wr_en;
        logic           rd_en;
        plit_addr_sel_t addr_sel;
        logic           save_hi;
        logic           save_lo;
        logic           div_start;
        logic           mul_lo;
        logic           res_load;
        plit_res_sel_t  res_sel;
    } plit_cmd_t;

    typedef struct packed {
        logic above_last;
        logic scan_more;
        logic at_first;
        logic div_done;
    } plit_status_t;

endpackage

>>> sv/plit_div.sv
// Iterative restoring divider producing a fixed-point fraction, one quotient bit per cycle.
// Requires numerator not above denominator and a nonzero denominator.
// Depends on plit_pkg.
module plit_div #(
    parameter int FRACTION_BITS = plit_pkg::PLIT_FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [plit_pkg::PLIT_VALUE_W-1:0]  num,
    input  logic [plit_pkg::PLIT_VALUE_W-1:0]  den,
    output logic                               done,
    output logic [FRACTION_BITS:0]             quo
);
    import plit_pkg::*;

    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    logic [PLIT_VALUE_W:0]   rem_reg;
    logic [PLIT_VALUE_W-1:0] den_reg;
    logic [FRACTION_BITS:0]  quo_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    run_reg;
    logic                    done_reg;
    logic                    ge;
    logic [PLIT_VALUE_W:0]   rem_sub;

    assign ge      = rem_reg >= {1'b0, den_reg};
    assign rem_sub = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(FRACTION_BITS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[FRACTION_BITS-1:0], ge};
            rem_reg <= {rem_sub[PLIT_VALUE_W-1:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> sv/plit_datapath.sv
// Datapath of the interpolation core: table memories, scan index, divider and multiplier.
// Driven by plit_ctrl through plit_cmd_t; reports through plit_status_t.
// Depends on plit_pkg and plit_div.
module plit_datapath #(
    parameter int FRACTION_BITS = plit_pkg::PLIT_FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [plit_pkg::PLIT_COUNT_W-1:0]  cfg_wdata,
    input  plit_pkg::plit_req_t                req,
    input  plit_pkg::plit_cmd_t                cmd,
    output plit_pkg::plit_status_t             status,
    output plit_pkg::plit_rsp_t                result
);
    import plit_pkg::*;

    localparam int TABLE_DEPTH = PLIT_TABLE_DEPTH;
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = (AW + 1 > PLIT_COUNT_W) ? AW + 1 : PLIT_COUNT_W;
    localparam int IW   = (AW + 1 > PLIT_INDEX_W) ? AW + 1 : PLIT_INDEX_W;
    localparam int WW   = FRACTION_BITS + 1;
    localparam int PW   = PLIT_VALUE_W + WW;
    localparam logic [WW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    logic [PLIT_VALUE_W-1:0] radius_table_reg  [TABLE_DEPTH];
    logic [PLIT_VALUE_W-1:0] density_table_reg [TABLE_DEPTH];

    logic [PLIT_COUNT_W-1:0] entries_used_reg;
    plit_req_t               req_reg;
    logic [PLIT_VALUE_W-1:0] rad_q_reg;
    logic [PLIT_VALUE_W-1:0] den_q_reg;
    logic [AW-1:0]           idx_reg;
    logic [PLIT_VALUE_W-1:0] rad_hi_reg;
    logic [PLIT_VALUE_W-1:0] den_hi_reg;
    logic [PLIT_VALUE_W-1:0] den_lo_reg;
    logic [PW-1:0]           prod_reg;
    plit_rsp_t               result_reg;

    logic [CW-1:0]           eu_ext;
    logic [AW-1:0]           last;
    logic [AW-1:0]           raddr;
    logic                    wr_ok;
    logic                    div_done;
    logic [WW-1:0]           frac;
    logic [PW-1:0]           acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_used_reg <= PLIT_COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            entries_used_reg <= cfg_wdata;
        end
    end

    assign eu_ext = CW'(entries_used_reg);

    always_comb
    begin
        if (eu_ext == '0)
        begin
            last = '0;
        end
        else if (eu_ext > CW'(TABLE_DEPTH))
        begin
            last = AW'(TABLE_DEPTH - 1);
        end
        else
        begin
            last = AW'(eu_ext - CW'(1));
        end
    end

    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_LAST: raddr = last;
            ADDR_ZERO: raddr = '0;
            ADDR_NEXT: raddr = idx_reg + AW'(1);
            ADDR_PREV: raddr = idx_reg - AW'(1);
            default:   raddr = '0;
        endcase
    end

    assign wr_ok = IW'(req_reg.entry_index) < IW'(TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_ok)
        begin
            radius_table_reg[AW'(req_reg.entry_index)]  <= req_reg.radius_value;
            density_table_reg[AW'(req_reg.entry_index)] <= req_reg.density_value;
        end
        rad_q_reg <= radius_table_reg[raddr];
        den_q_reg <= density_table_reg[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req;
        end
        if (cmd.rd_en)
        begin
            idx_reg <= raddr;
        end
        if (cmd.save_hi)
        begin
            rad_hi_reg <= rad_q_reg;
            den_hi_reg <= den_q_reg;
        end
        if (cmd.save_lo)
        begin
            den_lo_reg <= den_q_reg;
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= PW'(den_lo_reg) * PW'(ONE - frac);
        end
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_ABOVE:
                begin
                    result_reg.density_out <= den_q_reg;
                    result_reg.range_flag  <= RANGE_ABOVE;
                end
                RES_BELOW:
                begin
                    result_reg.density_out <= den_q_reg;
                    result_reg.range_flag  <= RANGE_BELOW;
                end
                default:
                begin
                    result_reg.density_out <= acc[FRACTION_BITS +: PLIT_VALUE_W];
                    result_reg.range_flag  <= RANGE_INSIDE;
                end
            endcase
        end
    end

    assign acc = prod_reg + PW'(den_hi_reg) * PW'(frac);

    plit_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (req_reg.radius_value - rad_q_reg),
        .den   (rad_hi_reg - rad_q_reg),
        .done  (div_done),
        .quo   (frac)
    );

    assign status.above_last = req_reg.radius_value > rad_q_reg;
    assign status.scan_more  = (idx_reg < last) && (rad_q_reg < req_reg.radius_value);
    assign status.at_first   = idx_reg == '0;
    assign status.div_done   = div_done;

    assign result = result_reg;

endmodule

>>> sv/plit_ctrl.sv
// Controller state machine of the interpolation core.
// Sequences write, bound check, scan, divide and multiply steps over plit_datapath.
// Depends on plit_pkg.
module plit_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   req_type,
    input  plit_pkg::plit_status_t status,
    output plit_pkg::plit_cmd_t    cmd,
    output logic                   busy,
    output logic                   done
);
    import plit_pkg::*;

    plit_state_t state_reg;
    plit_state_t state_next;
    logic        done_reg;
    logic        done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        cmd           = '0;
        cmd.addr_sel  = ADDR_LAST;
        cmd.res_sel   = RES_INTERP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    if (req_type == REQ_WRITE)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_CHK_LAST;
                    end
                end
            end
            S_WRITE:
            begin
                cmd.wr_en  = 1'b1;
                state_next = S_IDLE;
            end
            S_CHK_LAST:
            begin
                if (status.above_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_ABOVE;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_ZERO;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.scan_more)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_NEXT;
                end
                else if (status.at_first)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_BELOW;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.save_hi  = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_PREV;
                    state_next   = S_LOWER;
                end
            end
            S_LOWER:
            begin
                cmd.save_lo   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_INTERP;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;

endmodule

>>> sv/piecewise_linear_table_interp_core.sv
// Top level of the piecewise-linear table interpolation core.
// Joins the controller plit_ctrl and the datapath plit_datapath; depends on plit_pkg.
//
// Channel   Signals                 Transfer
// input     start, busy, req        word taken at a clock edge with start high and busy low
// result    done, result            word valid for one cycle while done is high
// config    cfg_we, cfg_wdata       entries_used written at a clock edge with cfg_we high
//
// A write word gives no result. A query reads the last entry first and returns its density
// when the radius lies above it, otherwise scans from entry zero with one table read per cycle,
// and when it interpolates it then runs the bit-serial divider and two multiply steps.
// Reset clears the controller and sets entries_used to 1; the tables hold no reset value.
// Results cannot be stalled; done rises in the cycle after the last step of a query.
module piecewise_linear_table_interp_core #(
    parameter int FRACTION_BITS = plit_pkg::PLIT_FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  plit_pkg::plit_req_t                req,
    output logic                               done,
    output plit_pkg::plit_rsp_t                result,
    input  logic                               cfg_we,
    input  logic [plit_pkg::PLIT_COUNT_W-1:0]  cfg_wdata
);
    import plit_pkg::*;

    plit_cmd_t    cmd;
    plit_status_t status;

    plit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    plit_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule
